[hdl/sorted_priority_queue_top_macros.svh]
// Assertion macros for the sorted priority queue checker.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/spq_pkg.sv]
// Shared codes and controller/datapath interface types for the sorted priority queue.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_SCAN,
        RD_UP,
        RD_DOWN,
        RD_HEAD
    } t_rd_mode;

    typedef enum logic [1:0] {
        PTR_ZERO,
        PTR_CNT_M1,
        PTR_IDX_P1
    } t_ptr_sel;

    typedef struct packed {
        logic     load;
        logic     pos_cap;
        logic     ptr_ld;
        t_ptr_sel ptr_sel;
        t_rd_mode rd_mode;
        logic     wr_up;
        logic     wr_down;
        logic     wr_new;
        logic     cnt_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic rd_pend;
        logic in_range;
        logic hit_ge;
        logic hit_eq;
        logic up_ok;
        logic down_ok;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_controller and spq_datapath.
//
// Usage:
//   Command channel: drive i_func and i_value and raise start; the item is
//   taken on a rising edge where start is high and busy is low. busy stays
//   high until the result has been shown.
//   Result channel: o_strobe is high for one cycle with o_status, o_position,
//   o_head_value, o_head_valid and o_entry_count. The receiver cannot stall;
//   the result must be captured in that cycle.
//   Sequence: a find or remove scans from entry 0 until a hit or the end; a
//   remove that hits then shifts the later entries down. An insert scans for
//   the first entry not less than the value, then shifts the entries from
//   there on up. Scan and shift move one entry per cycle through a
//   one-read one-write memory. A full insert or an unused code skips both.
//   o_strobe comes in the cycle before the next accept; one item is in flight.
//   Reset: synchronous, active low; empties the queue, busy and o_strobe low.
//   Memory contents are not cleared; entries past the count are never used.
`default_nettype none

module sorted_priority_queue_top import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [3:0]         o_position,
    output logic signed [31:0] o_head_value,
    output logic               o_head_valid,
    output logic [4:0]         o_entry_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    spq_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_status (o_status)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_value       (i_value),
        .o_stat        (dp_stat),
        .o_position    (o_position),
        .o_head_value  (o_head_value),
        .o_head_valid  (o_head_valid),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

[hdl/spq_datapath.sv]
// Datapath: value memory, entry count, scan/shift pointer and result fields.
// Depends on spq_pkg; driven by spq_controller commands.
`default_nettype none

module spq_datapath import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_value,
    output t_dp_stat           o_stat,
    output logic [3:0]         o_position,
    output logic signed [31:0] o_head_value,
    output logic               o_head_valid,
    output logic [4:0]         o_entry_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rdata;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_rd_idx;
    logic [IW-1:0]      r_pos;
    logic               r_rd_pend;

    logic [CW-1:0] n_ptr;
    logic          rd_en;
    logic          mem_rd;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    logic [31:0]   wdata;

    always_comb begin
        o_stat.full     = (r_count == CW'(CAPACITY));
        o_stat.rd_pend  = r_rd_pend;
        o_stat.in_range = (r_rd_idx < r_count);
        o_stat.hit_ge   = ($signed(r_rdata) >= r_value);
        o_stat.hit_eq   = (r_rdata == $unsigned(r_value));
        o_stat.up_ok    = (r_ptr >= CW'(r_pos)) && (r_ptr < r_count);
        o_stat.down_ok  = (r_ptr < r_count);
    end

    always_comb begin
        rd_en  = 1'b0;
        mem_rd = 1'b0;
        raddr  = r_ptr[IW-1:0];
        n_ptr  = r_ptr;
        case (i_cmd.rd_mode)
            RD_SCAN: begin
                rd_en = 1'b1;
                n_ptr = r_ptr + 1'b1;
            end
            RD_UP: begin
                rd_en = o_stat.up_ok;
                if (o_stat.up_ok) begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            RD_DOWN: begin
                rd_en = o_stat.down_ok;
                if (o_stat.down_ok) begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            RD_HEAD: begin
                raddr  = '0;
                mem_rd = 1'b1;
            end
            default: ;
        endcase
        if (i_cmd.ptr_ld) begin
            rd_en = 1'b0;
            unique case (i_cmd.ptr_sel)
                PTR_ZERO:   n_ptr = '0;
                PTR_CNT_M1: n_ptr = r_count - 1'b1;
                PTR_IDX_P1: n_ptr = r_rd_idx + 1'b1;
                default:    n_ptr = '0;
            endcase
        end
        if (rd_en && (r_ptr < CW'(CAPACITY))) begin
            mem_rd = 1'b1;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_pos;
        wdata = r_rdata;
        if (i_cmd.wr_up && r_rd_pend) begin
            we    = 1'b1;
            waddr = IW'(r_rd_idx + 1'b1);
        end
        if (i_cmd.wr_down && r_rd_pend) begin
            we    = 1'b1;
            waddr = IW'(r_rd_idx - 1'b1);
        end
        if (i_cmd.wr_new) begin
            we    = 1'b1;
            waddr = r_pos;
            wdata = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (mem_rd) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (rd_en) begin
            r_rd_idx <= r_ptr;
        end
        if (i_cmd.load) begin
            r_pos <= '0;
        end else if (i_cmd.pos_cap) begin
            r_pos <= IW'(r_rd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_rd_pend <= rd_en;
            if (i_cmd.wr_new) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_position    = 4'(r_pos);
    assign o_entry_count = 5'(r_count);
    assign o_head_valid  = (r_count != '0);
    assign o_head_value  = o_head_valid ? $signed(r_rdata) : 32'sd0;

endmodule

`default_nettype wire

[hdl/spq_controller.sv]
// Controller: sequences scan, shift, head read and result strobe for one item.
// Depends on spq_pkg; commands spq_datapath.
`default_nettype none

module spq_controller import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_strobe,
    output logic [1:0] o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_HEAD,
        S_DONE
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_func;
    logic [1:0] r_status;
    logic [1:0] n_status;
    logic       r_busy;
    logic       r_strobe;
    logic       hit;

    assign hit = (r_func == FUNC_INSERT) ? i_stat.hit_ge : i_stat.hit_eq;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.ptr_ld  = 1'b1;
                    o_cmd.ptr_sel = PTR_ZERO;
                    n_status      = ST_DONE;
                    unique case (i_func) inside
                        FUNC_INSERT: begin
                            if (i_stat.full) begin
                                n_status = ST_FULL;
                                n_state  = S_HEAD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FUNC_REMOVE, FUNC_FIND: n_state = S_SCAN;
                        default:                n_state = S_HEAD;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.rd_mode = RD_SCAN;
                if (i_stat.rd_pend) begin
                    if (!i_stat.in_range) begin
                        if (r_func == FUNC_INSERT) begin
                            o_cmd.pos_cap = 1'b1;
                            o_cmd.ptr_ld  = 1'b1;
                            o_cmd.ptr_sel = PTR_CNT_M1;
                            n_state       = S_SHIFT_UP;
                        end else begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_HEAD;
                        end
                    end else if (hit) begin
                        o_cmd.pos_cap = 1'b1;
                        unique case (r_func)
                            FUNC_INSERT: begin
                                o_cmd.ptr_ld  = 1'b1;
                                o_cmd.ptr_sel = PTR_CNT_M1;
                                n_state       = S_SHIFT_UP;
                            end
                            FUNC_REMOVE: begin
                                o_cmd.ptr_ld  = 1'b1;
                                o_cmd.ptr_sel = PTR_IDX_P1;
                                n_state       = S_SHIFT_DOWN;
                            end
                            default: n_state = S_HEAD;
                        endcase
                    end
                end
            end
            S_SHIFT_UP: begin
                o_cmd.rd_mode = RD_UP;
                o_cmd.wr_up   = 1'b1;
                if (!i_stat.up_ok && !i_stat.rd_pend) begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_HEAD;
                end
            end
            S_SHIFT_DOWN: begin
                o_cmd.rd_mode = RD_DOWN;
                o_cmd.wr_down = 1'b1;
                if (!i_stat.down_ok && !i_stat.rd_pend) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.rd_mode = RD_HEAD;
                n_state       = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_func   <= FUNC_INSERT;
            r_status <= ST_DONE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_busy   <= (n_state != S_IDLE);
            r_strobe <= (n_state == S_DONE);
            if ((r_state == S_IDLE) && i_start) begin
                r_func <= i_func;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;
    assign o_status = r_status;

endmodule

`default_nettype wire

[hdl/spq_checker.sv]
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top_macros.svh.
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"

module spq_checker import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic [1:0]         o_status,
    input logic [3:0]         o_position,
    input logic signed [31:0] o_head_value,
    input logic               o_head_valid,
    input logic [4:0]         o_entry_count
);

    `SPQ_ASSERT_SAME(a_strobe_in_busy, o_strobe, busy, "result strobe outside busy window")

    `SPQ_ASSERT_NEXT(a_single_strobe, o_strobe, !o_strobe, "result strobe longer than one cycle")

    `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !o_strobe, "item accepted without busy")

    `SPQ_ASSERT_SAME(a_empty_head, o_strobe && !o_head_valid, (o_head_value == 32'sd0) && (o_entry_count == 5'd0), "empty queue reports a head")

    `SPQ_ASSERT_SAME(a_full_drop, o_strobe && (o_status == ST_FULL), (o_position == 4'd0) && (o_entry_count == 5'(CAPACITY)), "full status with wrong fields")

endmodule

bind sorted_priority_queue_top spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_status      (o_status),
    .o_position    (o_position),
    .o_head_value  (o_head_value),
    .o_head_valid  (o_head_valid),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

[dv/sorted_priority_queue_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue_top: predicts every result from its own
// sorted copy of the stored values. Depends on spq_pkg and sorted_priority_queue_top.
module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int CAPACITY = 16;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE = 12;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         position;
        logic signed [31:0] head_value;
        logic               head_valid;
        logic [4:0]         entry_count;
    } t_spq_result;

    class spq_scoreboard;
        logic signed [31:0] sorted_vals[$];
        t_spq_result        awaited_results[$];
        int                 mismatches;

        function void note_item(logic [1:0] func, logic signed [31:0] value);
            t_spq_result exp_res;
            int          idx;
            bit          found;
            exp_res = '0;
            exp_res.status = ST_DONE;
            found = 1'b0;
            idx = 0;
            if (func == FUNC_INSERT) begin
                if (sorted_vals.size() >= CAPACITY) begin
                    exp_res.status = ST_FULL;
                end else begin
                    while (idx < sorted_vals.size() && sorted_vals[idx] < value) idx++;
                    sorted_vals.insert(idx, value);
                    exp_res.position = idx[3:0];
                end
            end else if (func == FUNC_REMOVE || func == FUNC_FIND) begin
                for (idx = 0; idx < sorted_vals.size() && !found; idx++) begin
                    if (sorted_vals[idx] == value) found = 1'b1;
                end
                if (found) begin
                    idx--;
                    exp_res.position = idx[3:0];
                    if (func == FUNC_REMOVE) sorted_vals.delete(idx);
                end else begin
                    exp_res.status = ST_NOT_FOUND;
                end
            end
            exp_res.head_valid = (sorted_vals.size() != 0);
            exp_res.head_value = (sorted_vals.size() != 0) ? sorted_vals[0] : 32'sd0;
            exp_res.entry_count = 5'(sorted_vals.size());
            awaited_results.push_back(exp_res);
        endfunction

        function void check_result(t_spq_result got);
            t_spq_result exp_res;
            if (awaited_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: status %0d pos %0d head %0d valid %0b count %0d",
                             got.status, got.position, got.head_value, got.head_valid,
                             got.entry_count);
                mismatches++;
                return;
            end
            exp_res = awaited_results.pop_front();
            if (got.status !== exp_res.status || got.position !== exp_res.position ||
                got.head_value !== exp_res.head_value ||
                got.head_valid !== exp_res.head_valid ||
                got.entry_count !== exp_res.entry_count) begin
                if (mismatches < 10)
                    $display({"mismatch: expected status %0d pos %0d head %0d valid %0b count %0d,",
                              " got status %0d pos %0d head %0d valid %0b count %0d"},
                             exp_res.status, exp_res.position, exp_res.head_value,
                             exp_res.head_valid, exp_res.entry_count, got.status,
                             got.position, got.head_value, got.head_valid, got.entry_count);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic signed [31:0] i_value;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [3:0]         o_position;
    logic signed [31:0] o_head_value;
    logic               o_head_valid;
    logic [4:0]         o_entry_count;

    spq_scoreboard      sb;
    logic signed [31:0] value_pool[POOL_SIZE];
    int                 cycles = 0;

    sorted_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_head_value (o_head_value),
        .o_head_valid (o_head_valid),
        .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_spq_result got;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && start && !busy) sb.note_item(i_func, i_value);
        if (i_rst_n && o_strobe) begin
            got.status      = o_status;
            got.position    = o_position;
            got.head_value  = o_head_value;
            got.head_valid  = o_head_valid;
            got.entry_count = o_entry_count;
            sb.check_result(got);
        end
    end

    task automatic send_item(input logic [1:0] func, input logic signed [31:0] value,
                             input bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 29) begin
            gap = $urandom_range(1, 25);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= func;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic refresh_pool();
        for (int k = 0; k < POOL_SIZE; k++) begin
            case ($urandom_range(0, 5))
                0:       value_pool[k] = $urandom;
                1:       value_pool[k] = 32'sh7fffffff;
                2:       value_pool[k] = 32'sh80000000;
                default: value_pool[k] = $urandom_range(0, 16) - 8;
            endcase
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 9) return $urandom;
        return roll[0] ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    function automatic logic [1:0] pick_func(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return FUNC_UNUSED;
        if (roll < 25) return FUNC_FIND;
        if (filling) return (roll < 80) ? FUNC_INSERT : FUNC_REMOVE;
        return (roll < 45) ? FUNC_INSERT : FUNC_REMOVE;
    endfunction

    initial begin
        int         done_items;
        logic [1:0] func;
        sb = new();
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_func  <= FUNC_INSERT;
        i_value <= 32'sd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(FUNC_FIND, 32'sd0, 1'b0);
        send_item(FUNC_REMOVE, 32'sd0, 1'b0);
        send_item(FUNC_UNUSED, 32'sh7fffffff, 1'b0);
        send_item(FUNC_INSERT, 32'sh7fffffff, 1'b0);
        send_item(FUNC_INSERT, 32'sh80000000, 1'b0);
        send_item(FUNC_INSERT, 32'sd0, 1'b0);
        send_item(FUNC_INSERT, -32'sd1, 1'b0);
        send_item(FUNC_INSERT, 32'sd1, 1'b0);
        send_item(FUNC_INSERT, 32'sd0, 1'b0);
        send_item(FUNC_FIND, 32'sd0, 1'b0);
        send_item(FUNC_FIND, 32'sd12345, 1'b0);
        send_item(FUNC_UNUSED, -32'sd1, 1'b0);
        repeat (11) send_item(FUNC_INSERT, $urandom, 1'b0);
        send_item(FUNC_REMOVE, 32'sh7fffffff, 1'b0);
        send_item(FUNC_REMOVE, 32'sh80000000, 1'b0);

        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (done_items % 60 == 0) refresh_pool();
            func = pick_func((done_items / 60) % 2 == 0);
            send_item(func, pick_value(), done_items >= 500 && done_items < 650);
            if (func != FUNC_UNUSED) done_items++;
        end
        start <= 1'b0;

        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
